### rtl/core/mmtag_pkg.sv
// Shared types and codes for the MM tag stream parser.
// Used by the front parser, the entry queue, the back end and the top level.
package mmtag_pkg;

  // Error codes carried in error_code
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_BASE   = 3'd1;
  localparam logic [2:0] ERR_STRAND = 3'd2;
  localparam logic [2:0] ERR_CODE   = 3'd3;
  localparam logic [2:0] ERR_DIGIT  = 3'd4;
  localparam logic [2:0] ERR_LONG   = 3'd5;
  localparam logic [2:0] ERR_CODES  = 3'd6;

  // Entries in the queue between front and back (power of two)
  localparam int QDEPTH = 4;

  // Input item: one character of the tag string
  typedef struct packed {
    logic [7:0] ch;
    logic       string_end;
  } mmtag_in_t;

  // Result item: one skip-count record or one error
  typedef struct packed {
    logic [7:0]  base_ltr;
    logic        strand_minus;
    logic [31:0] code_bytes;
    logic [2:0]  code_count;
    logic        ambiguous;
    logic [29:0] skip_count;
    logic        group_last;
    logic [2:0]  error_code;
    logic        run_last;
  } mmtag_out_t;

  // Queue entry: all results caused by one item (one or two records, or an error)
  typedef struct packed {
    logic [7:0]  base_ltr;
    logic        strand_minus;
    logic [31:0] code_bytes;
    logic [2:0]  code_count;
    logic        ambiguous;
    logic [29:0] cnt0;
    logic        last0;
    logic [29:0] cnt1;
    logic        two;
    logic [2:0]  error_code;
  } mmtag_entry_t;

endpackage

### rtl/core/mmtag_front.sv
// Front end of the MM tag parser: accepts characters, tracks the group state,
// accumulates counts and builds one queue entry per result-causing item. Uses mmtag_pkg.
module mmtag_front import mmtag_pkg::*; #(
  parameter int MAX_CODES  = 4,
  parameter int MAX_DIGITS = 9
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  mmtag_in_t    in_data_i,
  output logic         in_stall_o,
  input  logic         full_i,
  output logic         push_o,
  output mmtag_entry_t push_data_o
);

  localparam int CCW = $clog2(MAX_CODES + 1);
  localparam int DCW = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] PH_BASE   = 2'd0;
  localparam logic [1:0] PH_STRAND = 2'd1;
  localparam logic [1:0] PH_CODES  = 2'd2;
  localparam logic [1:0] PH_COUNTS = 2'd3;

  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  function automatic logic is_base(input logic [7:0] c);
    logic r;
    case (c) inside
      "A", "C", "G", "T", "U", "N", "a", "c", "g", "t", "u", "n": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_code(input logic [7:0] c);
    logic r;
    case (c) inside
      "a", "b", "c", "e", "f", "g", "h", "m", "n", "o",
      "A", "C", "G", "T", "U", "N": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  logic [1:0]     phase_q, phase_d;
  logic [7:0]     base_q, base_d;
  logic           strand_q, strand_d;
  logic [31:0]    codes_q, codes_d;
  logic [CCW-1:0] cc_q, cc_d;
  logic           flag_q, flag_d;
  logic [29:0]    dv_q, dv_d;
  logic [DCW-1:0] dc_q, dc_d;
  logic           hv_q, hv_d;
  logic [29:0]    hc_q, hc_d;
  logic           err_q, err_d;

  logic         accept;
  logic         err_now;
  logic         a_v, b_v, c_v;
  mmtag_entry_t ent;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Parse one character, then close the group on ';' or end of string
  always_comb begin
    logic [1:0]     ph_s;
    logic [7:0]     base_s;
    logic           strand_s;
    logic [31:0]    codes_s;
    logic [CCW-1:0] cc_s;
    logic           flag_s;
    logic [29:0]    dv_s;
    logic [DCW-1:0] dc_s;
    logic           hv_s;
    logic [29:0]    hc_s;
    logic           err_s;
    logic [2:0]     err_code;
    logic           close_req;
    logic [33:0]    acc;
    logic [3:0]     ccq_ext;
    logic [3:0]     ccs_ext;
    logic [29:0]    b_cnt;
    logic           b_last;
    logic [29:0]    c_cnt;
    logic [7:0]     ch;

    ch        = in_data_i.ch;
    ph_s      = phase_q;
    base_s    = base_q;
    strand_s  = strand_q;
    codes_s   = codes_q;
    cc_s      = cc_q;
    flag_s    = flag_q;
    dv_s      = dv_q;
    dc_s      = dc_q;
    hv_s      = hv_q;
    hc_s      = hc_q;
    err_now   = 1'b0;
    err_code  = ERR_NONE;
    a_v       = 1'b0;
    close_req = 1'b0;
    acc       = ({4'b0, dv_q} << 3) + ({4'b0, dv_q} << 1) + 34'(ch[3:0]);
    ccq_ext   = 4'(cc_q);

    if (!err_q) begin
      unique case (phase_q)
        PH_BASE: begin
          if (is_base(ch)) begin
            base_s   = ch;
            strand_s = 1'b0;
            codes_s  = '0;
            cc_s     = '0;
            flag_s   = 1'b0;
            ph_s     = PH_STRAND;
          end else begin
            err_now  = 1'b1;
            err_code = ERR_BASE;
          end
        end
        PH_STRAND: begin
          if (ch == CH_PLUS || ch == CH_MINUS) begin
            strand_s = (ch == CH_MINUS);
            ph_s     = PH_CODES;
          end else begin
            err_now  = 1'b1;
            err_code = ERR_STRAND;
          end
        end
        PH_CODES: begin
          if (ch == CH_QUEST || ch == CH_DOT) begin
            flag_s = (ch == CH_QUEST);
            ph_s   = PH_COUNTS;
          end else if (ch == CH_COMMA) begin
            ph_s = PH_COUNTS;
          end else if (ch == CH_SEMI) begin
            ph_s = PH_BASE;
          end else if (!is_code(ch)) begin
            err_now  = 1'b1;
            err_code = ERR_CODE;
          end else if (ccq_ext >= 4'(MAX_CODES)) begin
            err_now  = 1'b1;
            err_code = ERR_CODES;
          end else begin
            // store only the first four codes
            if (ccq_ext < 4'd4) begin
              case (ccq_ext[1:0])
                2'd0:    codes_s[7:0]   = ch;
                2'd1:    codes_s[15:8]  = ch;
                2'd2:    codes_s[23:16] = ch;
                default: codes_s[31:24] = ch;
              endcase
            end
            cc_s = cc_q + CCW'(1);
          end
        end
        default: begin
          if (ch == CH_COMMA) begin
            // move the finished count into the hold slot, release the old one
            if (dc_q != '0) begin
              a_v  = hv_q;
              hv_s = 1'b1;
              hc_s = dv_q;
              dv_s = '0;
              dc_s = '0;
            end
          end else if (ch == CH_SEMI) begin
            close_req = 1'b1;
          end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (dc_q >= DCW'(MAX_DIGITS)) begin
              err_now  = 1'b1;
              err_code = ERR_LONG;
            end else begin
              dv_s = acc[29:0];
              dc_s = dc_q + DCW'(1);
            end
          end else begin
            err_now  = 1'b1;
            err_code = ERR_DIGIT;
          end
        end
      endcase
    end

    // drop a held count on error
    if (err_now) begin
      hv_s = 1'b0;
    end
    err_s = err_q || err_now;

    // end of string closes an open group
    if (in_data_i.string_end && !err_s && ph_s == PH_COUNTS) begin
      close_req = 1'b1;
    end

    b_v    = close_req && hv_s;
    b_cnt  = hc_s;
    b_last = (dc_s == '0);
    c_v    = close_req && (dc_s != '0);
    c_cnt  = dv_s;

    if (close_req) begin
      hv_s = 1'b0;
      hc_s = '0;
      dv_s = '0;
      dc_s = '0;
      ph_s = PH_BASE;
    end

    // build the entry from the first two records in order
    ccs_ext          = 4'(cc_s);
    ent.base_ltr     = base_s;
    ent.strand_minus = strand_s;
    ent.code_bytes   = codes_s;
    ent.code_count   = (ccs_ext > 4'd4) ? 3'd4 : ccs_ext[2:0];
    ent.ambiguous    = flag_s;
    ent.two          = (a_v && b_v) || (b_v && c_v);
    ent.error_code   = ERR_NONE;
    if (a_v) begin
      ent.cnt0  = hc_q;
      ent.last0 = 1'b0;
      ent.cnt1  = b_cnt;
    end else if (b_v) begin
      ent.cnt0  = b_cnt;
      ent.last0 = b_last;
      ent.cnt1  = c_cnt;
    end else begin
      ent.cnt0  = c_cnt;
      ent.last0 = 1'b1;
      ent.cnt1  = c_cnt;
    end
    if (err_now) begin
      ent            = '0;
      ent.error_code = err_code;
    end

    phase_d  = ph_s;
    base_d   = base_s;
    strand_d = strand_s;
    codes_d  = codes_s;
    cc_d     = cc_s;
    flag_d   = flag_s;
    dv_d     = dv_s;
    dc_d     = dc_s;
    hv_d     = hv_s;
    hc_d     = hc_s;
    err_d    = err_s;

    // end of string returns everything to reset
    if (in_data_i.string_end) begin
      phase_d  = PH_BASE;
      base_d   = '0;
      strand_d = 1'b0;
      codes_d  = '0;
      cc_d     = '0;
      flag_d   = 1'b0;
      dv_d     = '0;
      dc_d     = '0;
      hv_d     = 1'b0;
      hc_d     = '0;
      err_d    = 1'b0;
    end
  end

  assign push_o      = accept && (err_now || a_v || b_v || c_v);
  assign push_data_o = ent;

  // Advance parser state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BASE;
      base_q   <= '0;
      strand_q <= 1'b0;
      codes_q  <= '0;
      cc_q     <= '0;
      flag_q   <= 1'b0;
      dv_q     <= '0;
      dc_q     <= '0;
      hv_q     <= 1'b0;
      hc_q     <= '0;
      err_q    <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      base_q   <= base_d;
      strand_q <= strand_d;
      codes_q  <= codes_d;
      cc_q     <= cc_d;
      flag_q   <= flag_d;
      dv_q     <= dv_d;
      dc_q     <= dc_d;
      hv_q     <= hv_d;
      hc_q     <= hc_d;
      err_q    <= err_d;
    end
  end

`ifndef SYNTHESIS
  // after an error the rest of the string yields nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni) err_q |-> !push_o)
    else $error("mmtag_front: push after error");
`endif

endmodule

### rtl/core/mmtag_queue.sv
// Short entry queue between the parser front and the result back end.
// Flip-flop storage, one push and one pop per cycle. Uses mmtag_pkg.
module mmtag_queue import mmtag_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  mmtag_entry_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output mmtag_entry_t head_o
);

  localparam int QPW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  mmtag_entry_t   mem_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Write storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("mmtag_queue: push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("mmtag_queue: pop from empty queue");
`endif

endmodule

### rtl/core/mmtag_back.sv
// Back end of the MM tag parser: splits queue entries into result items
// and drives the registered output channel. Uses mmtag_pkg.
module mmtag_back import mmtag_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  mmtag_entry_t q_head_i,
  output logic         pop_o,
  output logic         out_valid_o,
  output mmtag_out_t   out_data_o,
  input  logic         out_stall_i
);

  logic       out_valid_q, out_valid_d;
  mmtag_out_t out_data_q, out_data_d;
  logic       half_q, half_d;
  logic       load;
  logic       first;

  assign load  = q_valid_i && (!out_valid_q || !out_stall_i);
  assign first = q_head_i.two && !half_q;
  assign pop_o = load && !first;

  // Pick the next record of the head entry
  always_comb begin
    out_data_d.base_ltr     = q_head_i.base_ltr;
    out_data_d.strand_minus = q_head_i.strand_minus;
    out_data_d.code_bytes   = q_head_i.code_bytes;
    out_data_d.code_count   = q_head_i.code_count;
    out_data_d.ambiguous    = q_head_i.ambiguous;
    out_data_d.skip_count   = half_q ? q_head_i.cnt1 : q_head_i.cnt0;
    out_data_d.group_last   = half_q ? 1'b1 : q_head_i.last0;
    out_data_d.error_code   = q_head_i.error_code;
    out_data_d.run_last     = !first;

    half_d      = load ? first : half_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      half_q      <= half_d;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) half_q |-> q_valid_i)
    else $error("mmtag_back: second record pending without an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.run_last) |->
      (!out_data_o.group_last && out_data_o.error_code == ERR_NONE))
    else $error("mmtag_back: first of two records marked last or error");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error_code != ERR_NONE) |->
      (out_data_o.run_last && out_data_o.skip_count == '0))
    else $error("mmtag_back: malformed error result");
`endif

endmodule

### rtl/core/mm_tag_stream_parser_top.sv
// Latency: a result is written into the queue when its item is accepted, then loaded into the output register.
// Throughput: one character per cycle while the queue is not full; an item with two results gives them in turn,
// absorbed by the four-entry queue between parser and output stage.
// Reset (asynchronous, active low) returns the parser to expect-base and empties the queue.
// Top level of the MM tag stream parser; instantiates mmtag_front, mmtag_queue, mmtag_back.
module mm_tag_stream_parser_top import mmtag_pkg::*; #(
  parameter int MAX_CODES  = 4,
  parameter int MAX_DIGITS = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  mmtag_in_t  in_data_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output mmtag_out_t out_data_o,
  input  logic       out_stall_i
);

  logic         push;
  mmtag_entry_t push_data;
  logic         full;
  logic         pop;
  logic         q_valid;
  mmtag_entry_t q_head;

  mmtag_front #(
    .MAX_CODES  (MAX_CODES),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mmtag_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  mmtag_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
